@@ rtl/plex_pkg.sv @@
`timescale 1ns / 1ps

package plex_pkg;

    localparam int MAX_TEXT_LEN_DEF = 65536;

    typedef enum logic [4:0] {
        K_PLUS      = 5'd0,
        K_MINUS     = 5'd1,
        K_TIMES     = 5'd2,
        K_DIVIDE    = 5'd3,
        K_LPAREN    = 5'd4,
        K_RPAREN    = 5'd5,
        K_COMMA     = 5'd6,
        K_LT        = 5'd7,
        K_LTE       = 5'd8,
        K_NE        = 5'd9,
        K_GT        = 5'd10,
        K_GTE       = 5'd11,
        K_EQ        = 5'd12,
        K_STRING    = 5'd13,
        K_INT       = 5'd14,
        K_FLOAT     = 5'd15,
        K_IDENT     = 5'd16,
        K_AND       = 5'd17,
        K_OR        = 5'd18,
        K_NOT       = 5'd19,
        K_ABS       = 5'd20,
        K_INT2FLOAT = 5'd21,
        K_FLOAT2INT = 5'd22,
        K_END       = 5'd23,
        K_ERROR     = 5'd24
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE, S_LT, S_GT, S_BANG, S_STR, S_INT, S_FRAC0, S_FRAC, S_EXP0, S_EXPS, S_EXPD,
        S_KA, S_KAN, S_KAB, S_KO, S_KN, S_KNO, S_ID, S_KI, S_KF
    } t_scan;

    typedef struct packed {
        t_scan      state;
        logic [2:0] sub;
        logic       prev_bs;
        logic       skip;
    } t_ctl;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [30:0] value;
    } t_token;

    localparam t_ctl CTL_RESET = '{state: S_IDLE, sub: 3'd0, prev_bs: 1'b0, skip: 1'b0};

endpackage

@@ rtl/plex_scan.sv @@
`timescale 1ns / 1ps

module plex_scan #(
    parameter int MAX_TEXT_LEN = plex_pkg::MAX_TEXT_LEN_DEF,
    parameter int PW = $clog2(MAX_TEXT_LEN)
) (
    input  logic [7:0]        i_char,
    input  plex_pkg::t_ctl    i_ctl,
    input  logic [PW-1:0]     i_pos,
    input  logic [PW-1:0]     i_begin,
    input  logic [30:0]       i_acc,
    output plex_pkg::t_ctl    o_ctl,
    output logic [PW-1:0]     o_pos,
    output logic [PW-1:0]     o_begin,
    output logic [30:0]       o_acc,
    output plex_pkg::t_token  o_tok0,
    output plex_pkg::t_token  o_tok1,
    output logic [1:0]        o_count
);
    import plex_pkg::*;

    localparam logic [PW:0]   MAXW    = (PW+1)'(MAX_TEXT_LEN);
    localparam logic [PW-1:0] LASTPOS = PW'(MAX_TEXT_LEN - 1);
    localparam logic [30:0]   INT_SAT = 31'h7FFF_FFFF;
    localparam logic [7:0]    KI_TAIL [8] = '{"N", "T", "2", "F", "L", "O", "A", "T"};
    localparam logic [7:0]    KF_TAIL [8] = '{"L", "O", "A", "T", "2", "I", "N", "T"};

    function automatic t_token mk_tok(t_kind kind, logic [15:0] start, logic [15:0] len,
                                      logic [30:0] val);
        t_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = len;
        t.value  = val;
        return t;
    endfunction

    logic [7:0]  c;
    logic [7:0]  u;
    logic        dig;
    logic        ws;
    logic [PW:0] spn;
    logic [PW:0] spn1;
    logic [15:0] pos16;
    logic [15:0] beg16;
    logic [34:0] acc_wide;
    logic [30:0] acc_next;

    t_scan       id_state;
    logic [2:0]  id_sub;
    logic        id_pwb;
    logic        id_skip;
    logic [PW-1:0] id_begin;
    logic [30:0] id_acc;
    t_token      id_tok;
    logic        id_n;
    logic        id_end;

    logic        do_done;
    logic        do_fail;
    logic        do_ret;
    logic        use_idle;
    logic        line_end;
    t_kind       k;
    logic [30:0] rv;

    assign c     = i_char;
    assign u     = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    assign dig   = (c >= "0" && c <= "9");
    assign ws    = (c == " " || c == 8'h09 || c == 8'h0A);
    assign pos16 = 16'(i_pos);
    assign beg16 = 16'(i_begin);
    assign spn   = (i_pos >= i_begin) ? ({1'b0, i_pos} - {1'b0, i_begin})
                                      : ({1'b0, i_pos} + MAXW - {1'b0, i_begin});
    assign spn1  = spn + 1'b1;

    assign acc_wide = 35'({i_acc, 3'b000}) + 35'({i_acc, 1'b0}) + 35'(c[3:0]);
    assign acc_next = (acc_wide > 35'(INT_SAT)) ? INT_SAT : acc_wide[30:0];

    // Scan of a character from the start state; also used after a retracted token.
    always_comb begin
        id_state = S_IDLE;
        id_sub   = i_ctl.sub;
        id_pwb   = i_ctl.prev_bs;
        id_skip  = 1'b0;
        id_begin = i_begin;
        id_acc   = i_acc;
        id_tok   = mk_tok(K_ERROR, pos16, 16'd1, 31'd0);
        id_n     = 1'b0;
        id_end   = 1'b0;
        if (!ws) begin
            id_begin = i_pos;
            case (c)
                "+": begin id_n = 1'b1; id_tok.kind = K_PLUS;   end
                "-": begin id_n = 1'b1; id_tok.kind = K_MINUS;  end
                "*": begin id_n = 1'b1; id_tok.kind = K_TIMES;  end
                "/": begin id_n = 1'b1; id_tok.kind = K_DIVIDE; end
                "(": begin id_n = 1'b1; id_tok.kind = K_LPAREN; end
                ")": begin id_n = 1'b1; id_tok.kind = K_RPAREN; end
                ",": begin id_n = 1'b1; id_tok.kind = K_COMMA;  end
                "=": begin id_n = 1'b1; id_tok.kind = K_EQ;     end
                "<": id_state = S_LT;
                ">": id_state = S_GT;
                "!": id_state = S_BANG;
                "'": begin
                    id_state = S_STR;
                    id_pwb   = 1'b0;
                end
                ":": begin
                    id_state = S_ID;
                    id_sub   = 3'd0;
                end
                8'h00: begin
                    id_n   = 1'b1;
                    id_end = 1'b1;
                    id_tok = mk_tok(K_END, pos16, 16'd0, 31'd0);
                end
                default: begin
                    if (dig) begin
                        id_acc   = 31'(c[3:0]);
                        id_state = S_INT;
                    end else begin
                        case (u)
                            "A": id_state = S_KA;
                            "O": id_state = S_KO;
                            "N": id_state = S_KN;
                            "I": begin id_state = S_KI; id_sub = 3'd0; end
                            "F": begin id_state = S_KF; id_sub = 3'd0; end
                            default: begin
                                id_n    = 1'b1;
                                id_skip = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_ctl    = i_ctl;
        o_begin  = i_begin;
        o_acc    = i_acc;
        o_tok0   = mk_tok(K_ERROR, pos16, 16'd0, 31'd0);
        o_tok1   = mk_tok(K_END, pos16, 16'd0, 31'd0);
        o_count  = 2'd0;
        line_end = 1'b0;
        do_done  = 1'b0;
        do_fail  = 1'b0;
        do_ret   = 1'b0;
        use_idle = 1'b0;
        k        = K_ERROR;
        rv       = 31'd0;

        if (i_ctl.skip) begin
            if (c == 8'h00) begin
                o_tok0   = mk_tok(K_END, pos16, 16'd0, 31'd0);
                o_count  = 2'd1;
                line_end = 1'b1;
            end
        end else begin
            unique case (i_ctl.state) inside
                S_IDLE: use_idle = 1'b1;
                S_LT: begin
                    if (c == "=") begin do_done = 1'b1; k = K_LTE; end
                    else if (c == ">") begin do_done = 1'b1; k = K_NE; end
                    else begin do_ret = 1'b1; k = K_LT; end
                end
                S_GT: begin
                    if (c == "=") begin do_done = 1'b1; k = K_GTE; end
                    else begin do_ret = 1'b1; k = K_GT; end
                end
                S_BANG: begin
                    if (c == "=") begin do_done = 1'b1; k = K_NE; end
                    else do_fail = 1'b1;
                end
                S_STR: begin
                    if (c == 8'h00) do_fail = 1'b1;
                    else if (c != "'") o_ctl.prev_bs = (c == "\\");
                    else if (i_ctl.prev_bs) o_ctl.prev_bs = 1'b0;
                    else begin do_done = 1'b1; k = K_STRING; end
                end
                S_INT: begin
                    if (dig) o_acc = acc_next;
                    else if (c == ".") o_ctl.state = S_FRAC0;
                    else if (c == "E") o_ctl.state = S_EXP0;
                    else begin do_ret = 1'b1; k = K_INT; rv = i_acc; end
                end
                S_FRAC0: begin
                    if (dig) o_ctl.state = S_FRAC;
                    else do_fail = 1'b1;
                end
                S_FRAC, S_EXPD: begin
                    if (dig) o_ctl.state = i_ctl.state;
                    else if (i_ctl.state == S_FRAC && c == "E") o_ctl.state = S_EXP0;
                    else begin do_ret = 1'b1; k = K_FLOAT; end
                end
                S_EXP0: begin
                    if (c == "+" || c == "-") o_ctl.state = S_EXPS;
                    else if (dig) o_ctl.state = S_EXPD;
                    else do_fail = 1'b1;
                end
                S_EXPS: begin
                    if (dig) o_ctl.state = S_EXPD;
                    else do_fail = 1'b1;
                end
                S_KA: begin
                    if (u == "N") o_ctl.state = S_KAN;
                    else if (u == "B") o_ctl.state = S_KAB;
                    else do_fail = 1'b1;
                end
                S_KAN: begin
                    if (u == "D") begin do_done = 1'b1; k = K_AND; end
                    else do_fail = 1'b1;
                end
                S_KAB: begin
                    if (u == "S") begin do_done = 1'b1; k = K_ABS; end
                    else do_fail = 1'b1;
                end
                S_KO: begin
                    if (u == "R") begin do_done = 1'b1; k = K_OR; end
                    else do_fail = 1'b1;
                end
                S_KN: begin
                    if (u == "O") o_ctl.state = S_KNO;
                    else do_fail = 1'b1;
                end
                S_KNO: begin
                    if (u == "T") begin do_done = 1'b1; k = K_NOT; end
                    else do_fail = 1'b1;
                end
                S_ID: begin
                    if (c == 8'h00) do_fail = 1'b1;
                    else if (c == ":") begin
                        if (i_ctl.sub == 3'd3) begin do_done = 1'b1; k = K_IDENT; end
                        else o_ctl.sub = i_ctl.sub + 3'd1;
                    end
                end
                S_KI: begin
                    if (u != KI_TAIL[i_ctl.sub]) do_fail = 1'b1;
                    else if (i_ctl.sub == 3'd7) begin do_done = 1'b1; k = K_INT2FLOAT; end
                    else o_ctl.sub = i_ctl.sub + 3'd1;
                end
                S_KF: begin
                    if (u != KF_TAIL[i_ctl.sub]) do_fail = 1'b1;
                    else if (i_ctl.sub == 3'd7) begin do_done = 1'b1; k = K_FLOAT2INT; end
                    else o_ctl.sub = i_ctl.sub + 3'd1;
                end
                default: use_idle = 1'b1;
            endcase

            if (do_done) begin
                o_tok0      = mk_tok(k, beg16, 16'(spn1), 31'd0);
                o_count     = 2'd1;
                o_ctl.state = S_IDLE;
            end
            if (do_fail) begin
                if (c == 8'h00) begin
                    o_tok0   = mk_tok(K_ERROR, beg16, 16'(spn), 31'd0);
                    o_tok1   = mk_tok(K_END, pos16, 16'd0, 31'd0);
                    o_count  = 2'd2;
                    line_end = 1'b1;
                end else begin
                    o_tok0      = mk_tok(K_ERROR, beg16, 16'(spn1), 31'd0);
                    o_count     = 2'd1;
                    o_ctl.skip  = 1'b1;
                    o_ctl.state = S_IDLE;
                end
            end
            if (do_ret) begin
                o_tok0        = mk_tok(k, beg16, 16'(spn), rv);
                o_tok1        = id_tok;
                o_count       = id_n ? 2'd2 : 2'd1;
                o_ctl.state   = id_state;
                o_ctl.sub     = id_sub;
                o_ctl.prev_bs = id_pwb;
                o_ctl.skip    = id_skip;
                o_begin       = id_begin;
                o_acc         = id_acc;
                line_end      = id_end;
            end
            if (use_idle) begin
                o_tok0        = id_tok;
                o_count       = {1'b0, id_n};
                o_ctl.state   = id_state;
                o_ctl.sub     = id_sub;
                o_ctl.prev_bs = id_pwb;
                o_ctl.skip    = id_skip;
                o_begin       = id_begin;
                o_acc         = id_acc;
                line_end      = id_end;
            end
        end

        if (line_end) begin
            o_ctl   = CTL_RESET;
            o_pos   = '0;
            o_begin = '0;
            o_acc   = 31'd0;
        end else begin
            o_pos = (i_pos == LASTPOS) ? '0 : i_pos + 1'b1;
        end
    end

endmodule

@@ rtl/predicate_lexer.sv @@
`timescale 1ns / 1ps

// Predicate expression lexer.
// The slave stream carries one character per beat in s_axis_tdata; byte 0 ends the
// expression text. The master stream carries one token per beat: kind, start offset,
// length and integer value in m_axis_tdata, and m_axis_tlast marks the final token
// caused by one input character.
// The tokens caused by a character are presented on the cycle
// after its beat is accepted. A character is taken every cycle while the receiver
// keeps up. A character that yields two tokens (one that ends a number or a lone
// comparison and is a token of its own, or byte 0 inside an unfinished token) holds
// the input while the second token drains from the result register.
// Characters that yield no token (whitespace, or the middle of a token) still take
// an input beat each.
// After reset the lexer is in its start state with offset zero. Byte 0 always emits
// an end token and restarts offsets at zero.
// When the receiver stalls, pending tokens hold steady and the input is accepted
// again only once the result register has room for a full character's worth.

module predicate_lexer #(
    parameter int MAX_TEXT_LEN = plex_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [4:0] token_kind, [20:5] token_start,
                                        // [36:21] token_length, [67:37] int_value
    output logic        m_axis_tlast    // last_of_input
);
    import plex_pkg::*;

    localparam int PW = $clog2(MAX_TEXT_LEN);

    typedef struct packed {
        t_token tok;
        logic   last;
    } t_entry;

    t_ctl          r_ctl;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_begin;
    logic [30:0]   r_acc;
    logic [1:0]    r_cnt;
    t_entry        r_q0;
    t_entry        r_q1;

    t_ctl          n_ctl;
    logic [PW-1:0] n_pos;
    logic [PW-1:0] n_begin;
    logic [30:0]   n_acc;
    t_token        scan_tok0;
    t_token        scan_tok1;
    logic [1:0]    scan_count;

    logic s_acc;
    logic m_pop;

    plex_scan #(
        .MAX_TEXT_LEN(MAX_TEXT_LEN),
        .PW          (PW)
    ) u_scan (
        .i_char  (s_axis_tdata),
        .i_ctl   (r_ctl),
        .i_pos   (r_pos),
        .i_begin (r_begin),
        .i_acc   (r_acc),
        .o_ctl   (n_ctl),
        .o_pos   (n_pos),
        .o_begin (n_begin),
        .o_acc   (n_acc),
        .o_tok0  (scan_tok0),
        .o_tok1  (scan_tok1),
        .o_count (scan_count)
    );

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_pop         = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && m_axis_tready);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign m_axis_tdata = {4'b0000, r_q0.tok.value, r_q0.tok.length, r_q0.tok.start,
                           r_q0.tok.kind};
    assign m_axis_tlast = r_q0.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= CTL_RESET;
            r_pos   <= '0;
            r_begin <= '0;
            r_acc   <= 31'd0;
            r_cnt   <= 2'd0;
            r_q0    <= '0;
            r_q1    <= '0;
        end else begin
            if (s_acc) begin
                r_ctl   <= n_ctl;
                r_pos   <= n_pos;
                r_begin <= n_begin;
                r_acc   <= n_acc;
                r_cnt   <= scan_count;
                r_q0    <= '{tok: scan_tok0, last: (scan_count == 2'd1)};
                r_q1    <= '{tok: scan_tok1, last: 1'b1};
            end else if (m_pop) begin
                r_cnt <= r_cnt - 2'd1;
                r_q0  <= r_q1;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("Result count out of range.");

    a_two_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> (!r_q0.last && r_q1.last))
        else $error("Two pending tokens carry wrong last flags.");

    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd1 |-> r_q0.last)
        else $error("Single pending token is not marked last.");

    a_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_axis_tdata == 8'h00) |=>
            (r_pos == '0 && r_ctl.state == S_IDLE && !r_ctl.skip && r_cnt != 2'd0))
        else $error("End of text did not emit a token and restart.");

    a_skip_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_ctl.skip && s_axis_tdata != 8'h00) |=> (r_cnt == 2'd0))
        else $error("Discarded character produced a token.");

endmodule

@@ sim/predicate_lexer_tb.sv @@
`timescale 1ns / 1ps

module predicate_lexer_tb;
    import plex_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned TEXT_ITEMS  = 1900;
    localparam int unsigned MAX_GAP     = 13;
    localparam int unsigned DRAIN_WAIT  = 20;
    localparam logic [63:0] I2F_TAIL    = "NT2FLOAT";
    localparam logic [63:0] F2I_TAIL    = "LOAT2INT";

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [30:0] value;
        logic        last;
    } t_exp_token;

    typedef struct {
        logic [7:0]  ch;
        int unsigned gap;
    } t_char_beat;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;   // [4:0] kind, [20:5] start, [36:21] length, [67:37] value
    logic        m_axis_tlast;   // last token of one character

    predicate_lexer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    string op_words[14] = '{"+", "-", "*", "/", "(", ")", ",", "<", "<=", "<>", "!=", ">",
                            ">=", "="};
    string kw_words[6] = '{"AND", "OR", "NOT", "ABS", "INT2FLOAT", "FLOAT2INT"};
    string cut_words[9] = '{"'ab", ":x:y", "INT2F", "12.", "3E+", "7E", "AN", "!", "FLOA"};

    t_scan       lx_state  = S_IDLE;
    logic [2:0]  lx_sub    = 3'd0;
    logic [15:0] lx_pos    = 16'd0;
    logic [15:0] lx_begin  = 16'd0;
    logic        lx_bs     = 1'b0;
    logic [30:0] lx_acc    = 31'd0;
    logic        lx_skip   = 1'b0;
    logic        lx_line_end;
    t_exp_token  step_tokens[$];
    t_exp_token  expected_tokens[$];

    t_char_beat  text_beats[$];
    t_char_beat  next_beat;
    int unsigned gap_ceiling   = MAX_GAP;
    int unsigned hold_ceiling  = MAX_GAP;
    int unsigned send_wait     = 0;
    int unsigned hold_wait     = 0;
    int unsigned chars_total   = 0;
    int unsigned chars_taken   = 0;
    int unsigned tokens_seen   = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;

    function automatic void emit_token(t_kind kind, logic [15:0] start, logic [15:0] len,
                                       logic [30:0] val);
        t_exp_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = len;
        t.value  = val;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void clear_line(logic [15:0] pos);
        emit_token(K_END, pos, 16'd0, 31'd0);
        lx_state    = S_IDLE;
        lx_sub      = 3'd0;
        lx_pos      = 16'd0;
        lx_begin    = 16'd0;
        lx_bs       = 1'b0;
        lx_acc      = 31'd0;
        lx_skip     = 1'b0;
        lx_line_end = 1'b1;
    endfunction

    function automatic void reject_char(logic [7:0] c, logic [15:0] pos);
        if (c == 8'd0) begin
            emit_token(K_ERROR, lx_begin, pos - lx_begin, 31'd0);
            clear_line(pos);
        end else begin
            emit_token(K_ERROR, lx_begin, pos - lx_begin + 16'd1, 31'd0);
            lx_skip  = 1'b1;
            lx_state = S_IDLE;
        end
    endfunction

    function automatic void close_token(t_kind kind, logic [15:0] pos);
        emit_token(kind, lx_begin, pos - lx_begin + 16'd1, 31'd0);
        lx_state = S_IDLE;
    endfunction

    function automatic logic [7:0] upcase(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic void start_token(logic [7:0] c, logic [15:0] pos);
        logic [7:0] u;
        u = upcase(c);
        if (c == " " || c == "\t" || c == "\n") return;
        lx_begin = pos;
        case (c)
            "+": close_token(K_PLUS, pos);
            "-": close_token(K_MINUS, pos);
            "*": close_token(K_TIMES, pos);
            "/": close_token(K_DIVIDE, pos);
            "(": close_token(K_LPAREN, pos);
            ")": close_token(K_RPAREN, pos);
            ",": close_token(K_COMMA, pos);
            "=": close_token(K_EQ, pos);
            "<": lx_state = S_LT;
            ">": lx_state = S_GT;
            "!": lx_state = S_BANG;
            "'": begin
                lx_state = S_STR;
                lx_bs    = 1'b0;
            end
            ":": begin
                lx_state = S_ID;
                lx_sub   = 3'd0;
            end
            8'd0: clear_line(pos);
            default: begin
                if (c >= "0" && c <= "9") begin
                    lx_acc   = 31'(c - "0");
                    lx_state = S_INT;
                end else if (u == "A") begin
                    lx_state = S_KA;
                end else if (u == "O") begin
                    lx_state = S_KO;
                end else if (u == "N") begin
                    lx_state = S_KN;
                end else if (u == "I") begin
                    lx_state = S_KI;
                    lx_sub   = 3'd0;
                end else if (u == "F") begin
                    lx_state = S_KF;
                    lx_sub   = 3'd0;
                end else begin
                    reject_char(c, pos);
                end
            end
        endcase
    endfunction

    // Returns 1 when the character closed a token without being part of it.
    function automatic logic scan_char(logic [7:0] c, logic [15:0] pos);
        logic [7:0]  u;
        logic        is_dig;
        logic [34:0] grown;
        u = upcase(c);
        is_dig = (c >= "0" && c <= "9");
        case (lx_state) inside
            S_IDLE: start_token(c, pos);
            S_LT: begin
                if (c == "=") close_token(K_LTE, pos);
                else if (c == ">") close_token(K_NE, pos);
                else begin
                    emit_token(K_LT, lx_begin, pos - lx_begin, 31'd0);
                    lx_state = S_IDLE;
                    return 1'b1;
                end
            end
            S_GT: begin
                if (c == "=") close_token(K_GTE, pos);
                else begin
                    emit_token(K_GT, lx_begin, pos - lx_begin, 31'd0);
                    lx_state = S_IDLE;
                    return 1'b1;
                end
            end
            S_BANG: begin
                if (c == "=") close_token(K_NE, pos);
                else reject_char(c, pos);
            end
            S_STR: begin
                if (c == 8'd0) reject_char(c, pos);
                else if (c != "'") lx_bs = (c == "\\");
                else if (lx_bs) lx_bs = 1'b0;
                else close_token(K_STRING, pos);
            end
            S_INT: begin
                if (is_dig) begin
                    grown  = 35'(lx_acc) * 35'd10 + 35'(c - "0");
                    lx_acc = (grown > 35'h7FFF_FFFF) ? 31'h7FFF_FFFF : grown[30:0];
                end else if (c == ".") begin
                    lx_state = S_FRAC0;
                end else if (c == "E") begin
                    lx_state = S_EXP0;
                end else begin
                    emit_token(K_INT, lx_begin, pos - lx_begin, lx_acc);
                    lx_state = S_IDLE;
                    return 1'b1;
                end
            end
            S_FRAC0: begin
                if (is_dig) lx_state = S_FRAC;
                else reject_char(c, pos);
            end
            S_FRAC, S_EXPD: begin
                if (is_dig) return 1'b0;
                if (lx_state == S_FRAC && c == "E") begin
                    lx_state = S_EXP0;
                    return 1'b0;
                end
                emit_token(K_FLOAT, lx_begin, pos - lx_begin, 31'd0);
                lx_state = S_IDLE;
                return 1'b1;
            end
            S_EXP0: begin
                if (c == "+" || c == "-") lx_state = S_EXPS;
                else if (is_dig) lx_state = S_EXPD;
                else reject_char(c, pos);
            end
            S_EXPS: begin
                if (is_dig) lx_state = S_EXPD;
                else reject_char(c, pos);
            end
            S_KA: begin
                if (u == "N") lx_state = S_KAN;
                else if (u == "B") lx_state = S_KAB;
                else reject_char(c, pos);
            end
            S_KAN: begin
                if (u == "D") close_token(K_AND, pos);
                else reject_char(c, pos);
            end
            S_KAB: begin
                if (u == "S") close_token(K_ABS, pos);
                else reject_char(c, pos);
            end
            S_KO: begin
                if (u == "R") close_token(K_OR, pos);
                else reject_char(c, pos);
            end
            S_KN: begin
                if (u == "O") lx_state = S_KNO;
                else reject_char(c, pos);
            end
            S_KNO: begin
                if (u == "T") close_token(K_NOT, pos);
                else reject_char(c, pos);
            end
            S_ID: begin
                if (c == 8'd0) reject_char(c, pos);
                else if (c == ":") begin
                    if (lx_sub == 3'd3) close_token(K_IDENT, pos);
                    else lx_sub = lx_sub + 3'd1;
                end
            end
            S_KI: begin
                if (u != I2F_TAIL[63 - 8 * int'(lx_sub) -: 8]) reject_char(c, pos);
                else if (lx_sub == 3'd7) close_token(K_INT2FLOAT, pos);
                else lx_sub = lx_sub + 3'd1;
            end
            S_KF: begin
                if (u != F2I_TAIL[63 - 8 * int'(lx_sub) -: 8]) reject_char(c, pos);
                else if (lx_sub == 3'd7) close_token(K_FLOAT2INT, pos);
                else lx_sub = lx_sub + 3'd1;
            end
            default: begin
                lx_state = S_IDLE;
                start_token(c, pos);
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void predict_char(logic [7:0] c);
        logic [15:0] pos;
        logic        rescan;
        t_exp_token  t;
        pos = lx_pos;
        step_tokens.delete();
        lx_line_end = 1'b0;
        rescan = 1'b0;
        if (lx_skip) begin
            if (c == 8'd0) clear_line(pos);
        end else begin
            rescan = scan_char(c, pos);
        end
        if (rescan && !lx_line_end) begin
            lx_state = S_IDLE;
            start_token(c, pos);
        end
        if (!lx_line_end) lx_pos = pos + 16'd1;
        if (step_tokens.size() > 0) begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    function automatic void check_token(logic [71:0] data, logic last);
        t_exp_token got;
        t_exp_token want;
        got.kind   = t_kind'(data[4:0]);
        got.start  = data[20:5];
        got.length = data[36:21];
        got.value  = data[67:37];
        got.last   = last;
        if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected token: kind %0d start %0d length %0d value %0d last %0b",
                         got.kind, got.start, got.length, got.value, got.last);
            return;
        end
        want = expected_tokens.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected kind %0d start %0d length %0d value %0d last %0b",
                         want.kind, want.start, want.length, want.value, want.last);
                $display("          got      kind %0d start %0d length %0d value %0d last %0b",
                         got.kind, got.start, got.length, got.value, got.last);
            end
        end
    endfunction

    function automatic void put_char(logic [7:0] c);
        t_char_beat b;
        b.ch  = c;
        b.gap = $urandom_range(0, gap_ceiling);
        text_beats.push_back(b);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endfunction

    function automatic void put_keyword(string w);
        logic [7:0] c;
        for (int i = 0; i < w.len(); i++) begin
            c = w[i];
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + 8'd32;
            put_char(c);
        end
    endfunction

    function automatic void put_digits(int unsigned n);
        repeat (n) put_char(8'("0" + $urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] body_char(logic [7:0] banned);
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 1) == 1) c = 8'($urandom_range(32, 126));
            else c = 8'($urandom_range(1, 255));
        end while (c == "'" || c == "\\" || c == banned);
        return c;
    endfunction

    function automatic void put_token();
        case ($urandom_range(0, 9))
            0, 1: put_text(op_words[$urandom_range(0, 13)]);
            2: begin
                put_char("'");
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 5))
                        0: put_text("\\'");
                        1: put_text("\\n");
                        default: put_char(body_char("'"));
                    endcase
                end
                put_char("'");
            end
            3, 4: begin
                if ($urandom_range(0, 4) == 0)
                    put_text($urandom_range(0, 1) == 1 ? "2147483647" : "2147483648");
                else
                    put_digits($urandom_range(1, 12));
            end
            5: begin
                put_digits($urandom_range(1, 4));
                if ($urandom_range(0, 2) != 0) begin
                    put_char(".");
                    put_digits($urandom_range(1, 4));
                end
                if ($urandom_range(0, 1) == 1) begin
                    put_char("E");
                    case ($urandom_range(0, 2))
                        0: put_char("+");
                        1: put_char("-");
                        default: ;
                    endcase
                    put_digits($urandom_range(1, 3));
                end
            end
            6: begin
                put_char(":");
                repeat (4) begin
                    repeat ($urandom_range(0, 3)) put_char(body_char(":"));
                    put_char(":");
                end
            end
            default: put_keyword(kw_words[$urandom_range(0, 5)]);
        endcase
    endfunction

    function automatic void put_line();
        gap_ceiling = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
                0: put_char(" ");
                1: put_char("\t");
                2: put_char("\n");
                default: ;
            endcase
            if ($urandom_range(0, 39) == 0) put_char(8'($urandom_range(1, 255)));
            put_token();
        end
        case ($urandom_range(0, 9))
            0: put_char(8'($urandom_range(1, 255)));
            1, 2: put_keyword(cut_words[$urandom_range(0, 8)]);
            default: ;
        endcase
        put_char(8'd0);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL predicate_lexer");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'd0;
            send_wait = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                predict_char(s_axis_tdata);
                chars_taken++;
            end
            if (send_wait > 0) begin
                send_wait--;
                s_axis_tvalid <= 1'b0;
            end else if (text_beats.size() > 0) begin
                next_beat = text_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_beat.ch;
                send_wait = next_beat.gap;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_token(m_axis_tdata, m_axis_tlast);
                tokens_seen++;
                if (tokens_seen % 37 == 0)
                    hold_ceiling = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
                hold_wait = $urandom_range(0, hold_ceiling);
            end
            if (hold_wait > 0) begin
                hold_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        // Back-to-back operators, then tokens ending each other and a two-token byte 0.
        gap_ceiling = 0;
        put_text("<=<>!=>=+-*/(),=");
        put_char(8'd0);
        put_text("9<7>");
        put_char(8'd0);
        // Escaped quote, an illegal byte with skipped text, an unfinished
        // keyword at the end, and a carriage return.
        gap_ceiling = MAX_GAP;
        put_text("'\\''");
        put_char(8'hFF);
        put_text("x+");
        put_char(8'd0);
        put_text("AB");
        put_char(8'd0);
        put_char(8'h0D);
        put_char(8'd0);
        while (text_beats.size() < TEXT_ITEMS + 40) put_line();
        chars_total = text_beats.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (chars_taken < chars_total) @(posedge i_clk);
        while (expected_tokens.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (expected_tokens.size() > 0)
            $display("tokens never received: %0d", expected_tokens.size());
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("PASS predicate_lexer");
        end else begin
            $display("FAIL predicate_lexer");
        end
        $finish;
    end

endmodule

@@ predicate_lexer.f @@
rtl/plex_pkg.sv
rtl/plex_scan.sv
rtl/predicate_lexer.sv
sim/predicate_lexer_tb.sv
